### rtl/dfw_pkg.sv
// ----------------------------------------------------------------------------
// dfw_pkg
// Shared constants, codes and helpers for the depth-first postorder walker.
// ----------------------------------------------------------------------------
package dfw_pkg;

  localparam int VTX_N   = 64;
  localparam int IDX_W   = 6;
  localparam int DEPTH_W = 7;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_STEP  = 4'b0100,
    ST_POP   = 4'b1000
  } state_t;

  // index of the lowest set bit; isolate it, then encode the one-hot word
  function automatic logic [IDX_W-1:0] lowest_set(input logic [VTX_N-1:0] x);
    logic [VTX_N-1:0] oh;
    logic [IDX_W-1:0] idx;
    oh  = x & (~x + VTX_N'(1));
    idx = '0;
    for (int i = 0; i < VTX_N; i++) begin
      if (oh[i]) begin
        idx = idx | IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

### rtl/dfw_ram.sv
// ----------------------------------------------------------------------------
// dfw_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module dfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/dfs_postorder_walk.sv
// ----------------------------------------------------------------------------
// dfs_postorder_walk
// Depth-first walk of a 64-vertex adjacency matrix, vertices given in postorder.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): a load beat writes one adjacency row and
// the presence bit of one vertex slot. A run beat clears the visited marks
// and walks every present vertex, lowest slot first, always descending to
// the lowest unvisited present neighbour; the diagonal is ignored. Each
// vertex leaves on the result channel (out_valid/out_ready) as it finishes;
// out_last marks the final one of the run. A run with no present vertex
// gives no beat.
// Rows sit in a 64x64 RAM and the walk stack in a 64x6 RAM, both with
// registered read data. A push reads the new vertex's row; a pop of the
// root returns to the start state, any other pop reads the stack entry
// below and then that vertex's row. in_ready is high only while no run is
// in progress.
// A stalled result holds the walk at its next pop; pushes go on meanwhile.
// Reset clears presence and row valid flags (an unwritten row reads as zero),
// so no clearing pass is needed.
// ----------------------------------------------------------------------------
module dfs_postorder_walk
  import dfw_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_operation,
  input  logic [IDX_W-1:0]    in_vertex_slot,
  input  logic                in_is_present,
  input  logic [63:0]         in_neighbour_bits,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [IDX_W-1:0]    out_finished_vertex,
  output logic                out_last
);

  localparam logic [VTX_N-1:0] ONE = VTX_N'(1);

  state_t               state_r, state_nxt;
  logic [VTX_N-1:0]     present_r, present_nxt;
  logic [VTX_N-1:0]     visited_r, visited_nxt;
  logic [VTX_N-1:0]     rowv_r, rowv_nxt;
  logic                 rowv_q_r;
  logic [DEPTH_W-1:0]   depth_r, depth_nxt;
  logic [IDX_W-1:0]     top_r, top_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]     out_vtx_r, out_vtx_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 adj_we, adj_re;
  logic [IDX_W-1:0]     adj_waddr, adj_raddr;
  logic [VTX_N-1:0]     adj_rdata;
  logic                 stk_we, stk_re;
  logic [IDX_W-1:0]     stk_waddr, stk_raddr, stk_wdata, stk_rdata;

  logic [VTX_N-1:0]     avail, row, cand;
  logic [IDX_W-1:0]     start_pick, step_pick;
  logic [DEPTH_W-1:0]   depth_m2;
  logic                 out_free, push;

  dfw_ram #(.WIDTH(VTX_N), .DEPTH(VTX_N)) u_adj (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (in_neighbour_bits[VTX_N-1:0]),
    .re    (adj_re),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  dfw_ram #(.WIDTH(IDX_W), .DEPTH(VTX_N)) u_stk (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign avail      = present_r & ~visited_r;
  assign row        = rowv_q_r ? adj_rdata : '0;
  assign cand       = row & avail & ~(ONE << top_r);
  assign start_pick = lowest_set(avail);
  assign step_pick  = lowest_set(cand);
  assign depth_m2   = depth_r - DEPTH_W'(2);
  assign out_free   = !out_valid_r || out_ready;
  assign push       = (state_r == ST_STEP) && (cand != '0) && (depth_r < DEPTH_W'(VTX_N));
  assign in_ready   = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    present_nxt   = present_r;
    visited_nxt   = visited_r;
    rowv_nxt      = rowv_r;
    depth_nxt     = depth_r;
    top_nxt       = top_r;
    out_valid_nxt = out_valid_r;
    out_vtx_nxt   = out_vtx_r;
    out_last_nxt  = out_last_r;
    adj_we        = 1'b0;
    adj_waddr     = in_vertex_slot;
    adj_re        = 1'b0;
    adj_raddr     = '0;
    stk_we        = 1'b0;
    stk_waddr     = '0;
    stk_wdata     = '0;
    stk_re        = 1'b0;
    stk_raddr     = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_operation == OP_LOAD) begin
            if ({1'b0, in_vertex_slot} < DEPTH_W'(VTX_N)) begin
              adj_we                      = 1'b1;
              rowv_nxt[in_vertex_slot]    = 1'b1;
              present_nxt[in_vertex_slot] = in_is_present;
            end
          end else begin
            visited_nxt = '0;
            depth_nxt   = '0;
            state_nxt   = ST_START;
          end
        end
      end
      ST_START: begin
        if (avail == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          visited_nxt[start_pick] = 1'b1;
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wdata = start_pick;
          top_nxt   = start_pick;
          depth_nxt = DEPTH_W'(1);
          adj_re    = 1'b1;
          adj_raddr = start_pick;
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (push) begin
          visited_nxt[step_pick] = 1'b1;
          stk_we    = 1'b1;
          stk_waddr = depth_r[IDX_W-1:0];
          stk_wdata = step_pick;
          depth_nxt = depth_r + DEPTH_W'(1);
          top_nxt   = step_pick;
          adj_re    = 1'b1;
          adj_raddr = step_pick;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_vtx_nxt   = top_r;
          out_last_nxt  = (depth_r == DEPTH_W'(1)) && (avail == '0);
          depth_nxt     = depth_r - DEPTH_W'(1);
          if (depth_r == DEPTH_W'(1)) begin
            state_nxt = ST_START;
          end else begin
            stk_re    = 1'b1;
            stk_raddr = depth_m2[IDX_W-1:0];
            state_nxt = ST_POP;
          end
        end
      end
      ST_POP: begin
        top_nxt   = stk_rdata;
        adj_re    = 1'b1;
        adj_raddr = stk_rdata;
        state_nxt = ST_STEP;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      present_r   <= '0;
      visited_r   <= '0;
      rowv_r      <= '0;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      present_r   <= present_nxt;
      visited_r   <= visited_nxt;
      rowv_r      <= rowv_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    out_vtx_r  <= out_vtx_nxt;
    out_last_r <= out_last_nxt;
    if (adj_re) begin
      rowv_q_r <= rowv_r[adj_raddr];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_finished_vertex = out_vtx_r;
  assign out_last            = out_last_r;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(VTX_N))
    else $error("walk stack deeper than vertex count");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (depth_r == '0))
    else $error("walk left with a non-empty stack");

  a_top_visited: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP) |-> visited_r[top_r])
    else $error("stack top not marked visited");

  a_push_marks_one: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> ($countones(visited_r) == $past($countones(visited_r)) + 1))
    else $error("push did not mark exactly one new vertex");

  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_STEP) && !push && out_free && out_last_nxt)
      |=> (depth_r == '0) && (state_r == ST_START))
    else $error("last beat issued with vertices still on the stack");

endmodule
